@@ hdl/wavpcm_pkg.sv @@
// Shared types and constants for the sample-to-PCM16 converter.
// No dependencies; used by wavpcm_float_conv and wav_sample_to_pcm16.
`default_nettype none
package wavpcm_pkg;
   localparam int unsigned SampleWidth  = 32;
   localparam int unsigned PcmWidth     = 16;
   localparam int unsigned AddrWidth    = 3;
   localparam int unsigned ProdWidth    = 39;
   localparam int unsigned RoundWidth   = 25;

   // source_format codes
   localparam logic FmtPcm24 = 1'b0;
   localparam logic FmtFloat = 1'b1;

   // register byte address of source_format
   localparam logic [AddrWidth-1:0] AddrSourceFormat = 3'd0;

   // scale factor 32767 and clamp constants (single float fields)
   localparam logic [14:0] ScaleInt    = 15'd32767;
   localparam logic [7:0]  ExpOne      = 8'd127;
   localparam logic [23:0] MantOne     = 24'h800000;
   localparam logic [7:0]  ExpMinUsed  = 8'd112;
   localparam logic [7:0]  ExpBias150  = 8'd150;

   // decoded operand between the clamp and the multiplier
   typedef struct packed {
      logic        valid;
      logic        is_float;
      logic        sign;
      logic        zero;
      logic [7:0]  expo;
      logic [23:0] mant;
      logic [15:0] pcm;
   } dec_type;
endpackage
`default_nettype wire

@@ hdl/wavpcm_float_conv.sv @@
// Four-stage conversion pipeline: decode and clamp, multiply by 32767,
// round to single precision, truncate and apply sign, or pass 24-bit PCM through. Uses wavpcm_pkg.
`default_nettype none
module wavpcm_float_conv (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire logic                                in_is_float,
   input  wire logic [wavpcm_pkg::SampleWidth-1:0]  in_bits,
   output logic                                     out_valid,
   output logic signed [wavpcm_pkg::PcmWidth-1:0]   out_pcm
);
   // stage 1: decode, clamp
   wavpcm_pkg::dec_type s1_in, s1_ff;
   logic [7:0]  f_exp;
   logic [22:0] f_frac;
   logic        f_nan, f_big;

   always_comb begin
      f_exp  = in_bits[30:23];
      f_frac = in_bits[22:0];
      f_nan  = (f_exp == 8'hFF) && (f_frac != 23'd0);
      f_big  = (f_exp > wavpcm_pkg::ExpOne) ||
               ((f_exp == wavpcm_pkg::ExpOne) && (f_frac != 23'd0));
      s1_in.valid    = in_valid;
      s1_in.is_float = in_is_float;
      s1_in.sign     = in_bits[31];
      s1_in.pcm      = in_bits[23:8];
      s1_in.zero     = f_nan || (!f_big && (f_exp < wavpcm_pkg::ExpMinUsed));
      if (f_big) begin
         s1_in.expo = wavpcm_pkg::ExpOne;
         s1_in.mant = wavpcm_pkg::MantOne;
      end else begin
         s1_in.expo = f_exp;
         s1_in.mant = {1'b1, f_frac};
      end
   end

   // stage 2: product
   logic [wavpcm_pkg::ProdWidth-1:0] prod_in, prod_ff;
   logic v2_ff, flt2_ff, sgn2_ff, zero2_ff;
   logic [7:0]  exp2_ff;
   logic [15:0] pcm2_ff;
   assign prod_in = ProdWidthCast(s1_ff.mant);

   function automatic logic [wavpcm_pkg::ProdWidth-1:0] ProdWidthCast(
         input logic [23:0] m);
      ProdWidthCast = {15'd0, m} * {24'd0, wavpcm_pkg::ScaleInt};
   endfunction

   // stage 3: round to 24 significant bits, nearest-even
   logic [wavpcm_pkg::RoundWidth-1:0] rq_in, rq_ff;
   logic [4:0]  k_in, k_ff;
   logic        lead, guard, sticky, lsb, up;
   logic [23:0] kept;
   logic [7:0]  sh;
   logic v3_ff, flt3_ff, sgn3_ff, zero3_ff;
   logic [15:0] pcm3_ff;

   always_comb begin
      lead = prod_ff[38];
      if (lead) begin
         kept   = prod_ff[38:15];
         guard  = prod_ff[14];
         sticky = |prod_ff[13:0];
      end else begin
         kept   = prod_ff[37:14];
         guard  = prod_ff[13];
         sticky = |prod_ff[12:0];
      end
      lsb   = kept[0];
      up    = guard && (sticky || lsb);
      rq_in = {1'b0, kept} + {24'd0, up};
      sh    = wavpcm_pkg::ExpBias150 - exp2_ff;
      k_in  = 5'(sh - (lead ? 8'd15 : 8'd14));
   end

   // stage 4: truncate toward zero, apply sign, pick format
   logic [15:0] mag;
   logic [15:0] res_in, res_ff;
   logic        v4_ff;
   always_comb begin
      mag = 16'(rq_ff >> k_ff);
      if (!flt3_ff) begin
         res_in = pcm3_ff;
      end else if (zero3_ff) begin
         res_in = 16'd0;
      end else if (sgn3_ff) begin
         res_in = 16'd0 - mag;
      end else begin
         res_in = mag;
      end
   end

   // advance valid bits under reset, payload always
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
      end else begin
         s1_ff.valid <= s1_in.valid;
         v2_ff       <= s1_ff.valid;
         v3_ff       <= v2_ff;
         v4_ff       <= v3_ff;
      end
      s1_ff.is_float <= s1_in.is_float;
      s1_ff.sign     <= s1_in.sign;
      s1_ff.zero     <= s1_in.zero;
      s1_ff.expo     <= s1_in.expo;
      s1_ff.mant     <= s1_in.mant;
      s1_ff.pcm      <= s1_in.pcm;
      prod_ff  <= prod_in;
      flt2_ff  <= s1_ff.is_float;
      sgn2_ff  <= s1_ff.sign;
      zero2_ff <= s1_ff.zero;
      exp2_ff  <= s1_ff.expo;
      pcm2_ff  <= s1_ff.pcm;
      rq_ff    <= rq_in;
      k_ff     <= k_in;
      flt3_ff  <= flt2_ff;
      sgn3_ff  <= sgn2_ff;
      zero3_ff <= zero2_ff;
      pcm3_ff  <= pcm2_ff;
      res_ff   <= res_in;
   end

   assign out_valid = v4_ff;
   assign out_pcm   = signed'(res_ff);
endmodule
`default_nettype wire

@@ hdl/wav_sample_to_pcm16.sv @@
// Top level of the sample-to-PCM16 converter with its register port.
// Depends on wavpcm_pkg and wavpcm_float_conv.
//
// One sample is taken every cycle (busy stays low) and its result comes out
// on rsp_valid for one cycle, after passing through the four register
// stages of the conversion pipeline (clamp, multiply, round, truncate).
// The receiver cannot stall. source_format sits at byte 0.
`default_nettype none
module wav_sample_to_pcm16 (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic [wavpcm_pkg::SampleWidth-1:0]       req_sample_bits,
   output logic                                          rsp_valid,
   output logic signed [wavpcm_pkg::PcmWidth-1:0]        rsp_pcm_sample,
   input  wire logic                                     psel,
   input  wire logic                                     penable,
   input  wire logic                                     pwrite,
   input  wire logic [wavpcm_pkg::AddrWidth-1:0]         paddr,
   input  wire logic [31:0]                              pwdata,
   output logic [31:0]                                   prdata,
   output logic                                          pready
);
   logic fmt_ff, fmt_in;
   logic hit;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign hit    = (paddr[2] == wavpcm_pkg::AddrSourceFormat[2]);

   // write source_format on a completed write beat
   always_comb begin
      fmt_in = fmt_ff;
      if (psel && penable && pwrite && pready && hit) begin
         fmt_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= wavpcm_pkg::FmtPcm24;
      end else begin
         fmt_ff <= fmt_in;
      end
   end

   assign prdata = hit ? {31'd0, fmt_ff} : 32'd0;

   wavpcm_float_conv u_conv (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start && !busy),
      .in_is_float (fmt_ff == wavpcm_pkg::FmtFloat),
      .in_bits     (req_sample_bits),
      .out_valid   (rsp_valid),
      .out_pcm     (rsp_pcm_sample)
   );
endmodule
`default_nettype wire
